/* rtl/pid_controller_clamped_unit_macros.svh */
`ifndef PID_CONTROLLER_CLAMPED_UNIT_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PCU_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PCU_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

/* rtl/pcu_pkg.sv */
package pcu_pkg;

	localparam int DATA_W      = 32;
	localparam int FRAC_BITS   = 16;
	localparam int ACC_W       = 48;
	localparam int MUL_W       = DATA_W + 1;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int WIDE_W      = 2 * DATA_W;
	localparam int P_W         = WIDE_W - FRAC_BITS;
	localparam int TERM_EXP    = 60;
	localparam int I_W         = TERM_EXP + 2;
	localparam int D_W         = TERM_EXP;
	localparam int SUM_W       = WIDE_W;
	localparam int DEN_W       = 38;
	localparam int DIV_W       = WIDE_W;
	localparam int DERIV_SCALE = 50;
	localparam int CFG_IDX_W   = 3;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_OUT_MAX,
		REG_OUT_MIN
	} reg_idx_t;

	typedef struct packed {
		data_t gain_p;
		data_t gain_i;
		data_t gain_d;
		data_t out_max;
		data_t out_min;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ERR,
		OP_MUL_P,
		OP_MUL_INC,
		OP_ACC,
		OP_MUL_IL,
		OP_MUL_IH,
		OP_ISUM,
		OP_MUL_DEN,
		OP_MUL_NUM,
		OP_DIV_START,
		OP_DVAL,
		OP_SUM
	} op_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_DT_ZERO,
		COND_DIV_BUSY,
		COND_OUT_FULL
	} cond_t;

	localparam int STEPS  = 13;
	localparam int STEP_W = $clog2(STEPS);
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_DIV_WAIT = step_t'(10);
	localparam step_t ST_SUM      = step_t'(12);

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		logic  last;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic en;
		logic load;
	} ctrl_t;

	typedef struct packed {
		logic dt_zero;
		logic div_busy;
		logic out_full;
	} stat_t;

	// Control program: one word per step.
	function automatic uword_t ucode(step_t s);
		uword_t w;
		unique case (s)
			step_t'(0):  w = '{OP_ERR,       COND_NONE,     step_t'(0),  1'b0};
			step_t'(1):  w = '{OP_MUL_P,     COND_NONE,     step_t'(0),  1'b0};
			step_t'(2):  w = '{OP_MUL_INC,   COND_NONE,     step_t'(0),  1'b0};
			step_t'(3):  w = '{OP_ACC,       COND_NONE,     step_t'(0),  1'b0};
			step_t'(4):  w = '{OP_MUL_IL,    COND_NONE,     step_t'(0),  1'b0};
			step_t'(5):  w = '{OP_MUL_IH,    COND_NONE,     step_t'(0),  1'b0};
			step_t'(6):  w = '{OP_ISUM,      COND_NONE,     step_t'(0),  1'b0};
			step_t'(7):  w = '{OP_MUL_DEN,   COND_DT_ZERO,  ST_SUM,      1'b0};
			step_t'(8):  w = '{OP_MUL_NUM,   COND_NONE,     step_t'(0),  1'b0};
			step_t'(9):  w = '{OP_DIV_START, COND_NONE,     step_t'(0),  1'b0};
			step_t'(10): w = '{OP_NOP,       COND_DIV_BUSY, ST_DIV_WAIT, 1'b0};
			step_t'(11): w = '{OP_DVAL,      COND_NONE,     step_t'(0),  1'b0};
			step_t'(12): w = '{OP_SUM,       COND_OUT_FULL, ST_SUM,      1'b1};
			default:     w = '{OP_NOP,       COND_NONE,     step_t'(0),  1'b1};
		endcase
		return w;
	endfunction

endpackage

/* rtl/pid_controller_clamped_unit.sv */
// Clamped PID controller, signed Q16.16, with conditional-integration anti-windup.
// Input channel (in_valid/in_stall): target, measured, step_time and clear_integral;
// an item is taken on an edge with in_valid high and in_stall low.
// Output channel (out_valid/out_stall): drive, error_value and clamped, one item per
// input item, held in an output register until taken.
// Gains and clamp limits are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, as the block itself does not enforce it. Each
// item runs a 13-step control program on one shared 33x33 multiplier; the
// derivative quotient comes from a radix-4 divider, skipped when step_time is zero.
// in_stall stays high for the whole program, so a new item is taken only after the
// previous item's program has finished.
// A finished result waits in the output register; the next item is already taken
// and runs, and only its last step holds while out_stall keeps the register full.
// Reset clears the integral, the last measurement and the windup flag, sets the
// gains to 0 and the limits to the full 32-bit range, and drops out_valid.
`include "pid_controller_clamped_unit_macros.svh"

module pid_controller_clamped_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  target,
	input  logic signed [31:0]  measured,
	input  logic        [31:0]  step_time,
	input  logic                clear_integral,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  drive,
	output logic signed [31:0]  error_value,
	output logic                clamped
);
	import pcu_pkg::*;

	cfg_t  cfg_q;
	ctrl_t ctrl;
	stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p  <= '0;
			cfg_q.gain_i  <= '0;
			cfg_q.gain_d  <= '0;
			cfg_q.out_max <= {1'b0, {(DATA_W-1){1'b1}}};
			cfg_q.out_min <= {1'b1, {(DATA_W-1){1'b0}}};
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GAIN_P:  cfg_q.gain_p  <= cfg_data;
				REG_GAIN_I:  cfg_q.gain_i  <= cfg_data;
				REG_GAIN_D:  cfg_q.gain_d  <= cfg_data;
				REG_OUT_MAX: cfg_q.out_max <= cfg_data;
				REG_OUT_MIN: cfg_q.out_min <= cfg_data;
				default: ;
			endcase
		end
	end

	pcu_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	pcu_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.cfg            (cfg_q),
		.target         (target),
		.measured       (measured),
		.step_time      (step_time),
		.clear_integral (clear_integral),
		.out_stall      (out_stall),
		.stat           (stat),
		.out_valid      (out_valid),
		.drive          (drive),
		.error_value    (error_value),
		.clamped        (clamped)
	);

	`PCU_ASSERT_NEXT(a_accept_starts_program, clk, arst_n, in_valid && !in_stall, in_stall)
	`PCU_ASSERT_NEXT(a_sum_fills_output, clk, arst_n, ctrl.en && ctrl.op == OP_SUM, out_valid)
	`PCU_ASSERT_IMPLY(a_div_idle_at_start, clk, arst_n, ctrl.en && ctrl.op == OP_DIV_START, !stat.div_busy)

endmodule

/* rtl/pcu_seq.sv */
module pcu_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  pcu_pkg::stat_t stat,
	output pcu_pkg::ctrl_t ctrl
);
	import pcu_pkg::*;

	logic   busy_q;
	step_t  step_q;
	uword_t uw;
	logic   jump;
	logic   hold;
	logic   accept;

	assign uw = ucode(step_q);

	always_comb begin
		case (uw.cond)
			COND_DT_ZERO:  jump = stat.dt_zero;
			COND_DIV_BUSY: jump = stat.div_busy;
			COND_OUT_FULL: jump = stat.out_full;
			default:       jump = 1'b0;
		endcase
	end

	// hold the final step while the result register is still occupied
	assign hold      = (uw.cond == COND_OUT_FULL) && stat.out_full;
	assign accept    = in_valid && !busy_q;
	assign in_stall  = busy_q;
	assign ctrl.op   = uw.op;
	assign ctrl.en   = busy_q && !hold;
	assign ctrl.load = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (jump) begin
				step_q <= uw.target;
			end else if (uw.last) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + step_t'(1);
			end
		end
	end

endmodule

/* rtl/pcu_div.sv */
module pcu_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pcu_pkg::DIV_W-1:0] dividend,
	input  logic [pcu_pkg::DEN_W-1:0] divisor,
	output logic                      busy,
	output logic [pcu_pkg::DIV_W-1:0] quotient
);
	import pcu_pkg::*;

	localparam int RADIX_BITS = 2;
	localparam int ROUNDS     = DIV_W / RADIX_BITS;
	localparam int CNT_W      = $clog2(ROUNDS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROUNDS - 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   rem_q;
	logic [DIV_W-1:0] work_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_n;
	logic [DIV_W-1:0] work_n;

	// restoring division, two quotient bits per cycle; quotient shifts in below the dividend
	always_comb begin
		rem_n  = rem_q;
		work_n = work_q;
		for (int k = 0; k < RADIX_BITS; k++) begin
			rem_n  = {rem_n[DEN_W-1:0], work_n[DIV_W-1]};
			work_n = {work_n[DIV_W-2:0], 1'b0};
			if (rem_n >= {1'b0, den_q}) begin
				rem_n     = rem_n - {1'b0, den_q};
				work_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			work_q <= dividend;
			den_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= rem_n;
			work_q <= work_n;
		end
	end

	assign busy     = busy_q;
	assign quotient = work_q;

endmodule

/* rtl/pcu_dp.sv */
module pcu_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pcu_pkg::ctrl_t        ctrl,
	input  pcu_pkg::cfg_t         cfg,
	input  logic signed [31:0]    target,
	input  logic signed [31:0]    measured,
	input  logic        [31:0]    step_time,
	input  logic                  clear_integral,
	input  logic                  out_stall,
	output pcu_pkg::stat_t        stat,
	output logic                  out_valid,
	output logic signed [31:0]    drive,
	output logic signed [31:0]    error_value,
	output logic                  clamped
);
	import pcu_pkg::*;

	localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] D_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] D_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [SUM_W:0] TERM_HI    = (SUM_W+1)'(1) << TERM_EXP;
	localparam logic signed [SUM_W:0] TERM_LO    = -TERM_HI;

	// item and intermediate registers
	data_t                    tgt_q;
	data_t                    meas_q;
	logic        [DATA_W-1:0] dt_q;
	logic                     clr_q;
	data_t                    err_q;
	logic signed [MUL_W-1:0]  diff_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [P_W-1:0]    p_q;
	data_t                    il_q;
	logic signed [I_W-1:0]    i_q;
	logic signed [D_W-1:0]    d_q;
	logic        [DEN_W-1:0]  den_q;
	logic                     neg_q;
	data_t                    drive_q;
	data_t                    error_q;
	logic                     clamped_q;

	// controller state
	logic signed [ACC_W-1:0]  acc_q;
	data_t                    prev_q;
	logic                     windup_q;
	logic                     out_valid_q;

	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic                     mul_en;
	logic signed [PROD_W-1:0] prod_n;
	logic signed [MUL_W-1:0]  err_wide;
	data_t                    err_n;
	logic signed [ACC_W:0]    acc_sum;
	logic signed [ACC_W-1:0]  acc_n;
	logic signed [P_W-1:0]    inc;
	logic signed [SUM_W:0]    i_sum;
	logic signed [I_W-1:0]    i_n;
	logic        [DIV_W-1:0]  mag;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  lim_hi;
	logic signed [SUM_W-1:0]  lim_lo;
	data_t                    drive_n;
	logic                     hit;
	logic                     div_start;
	logic                     div_busy;
	logic        [DIV_W-1:0]  quot;
	logic        [DIV_W-1:0]  quot_s;

	always_comb begin
		err_wide = MUL_W'(tgt_q) - MUL_W'(meas_q);
		if (err_wide[MUL_W-1] != err_wide[MUL_W-2]) begin
			err_n = err_wide[MUL_W-1] ? D_MIN : D_MAX;
		end else begin
			err_n = err_wide[DATA_W-1:0];
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (ctrl.op)
			OP_MUL_P: begin
				mul_a = MUL_W'(cfg.gain_p);
				mul_b = MUL_W'(err_q);
			end
			OP_MUL_INC: begin
				mul_a = MUL_W'(err_q);
				mul_b = $signed({1'b0, dt_q});
			end
			OP_MUL_IL: begin
				mul_a = MUL_W'(cfg.gain_i);
				mul_b = MUL_W'($signed({1'b0, acc_q[FRAC_BITS-1:0]}));
			end
			OP_MUL_IH: begin
				mul_a = MUL_W'(cfg.gain_i);
				mul_b = MUL_W'($signed(acc_q[ACC_W-1:FRAC_BITS]));
			end
			OP_MUL_DEN: begin
				mul_a = $signed({1'b0, dt_q});
				mul_b = MUL_W'(DERIV_SCALE);
			end
			OP_MUL_NUM: begin
				mul_a = MUL_W'(cfg.gain_d);
				mul_b = diff_q;
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign prod_n = mul_a * mul_b;

	always_comb begin
		inc     = prod_q[WIDE_W-1:FRAC_BITS];
		acc_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(inc);
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_n = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_n = acc_sum[ACC_W-1:0];
		end
	end

	always_comb begin
		i_sum = (SUM_W+1)'($signed(prod_q[WIDE_W-1:0])) + (SUM_W+1)'(il_q);
		if (i_sum > TERM_HI) begin
			i_n = TERM_HI[I_W-1:0];
		end else if (i_sum < TERM_LO) begin
			i_n = TERM_LO[I_W-1:0];
		end else begin
			i_n = i_sum[I_W-1:0];
		end
	end

	assign mag = prod_q[WIDE_W-1] ? (~prod_q[WIDE_W-1:0] + DIV_W'(1)) : prod_q[WIDE_W-1:0];
	assign quot_s = neg_q ? (~quot + DIV_W'(1)) : quot;

	always_comb begin
		sum    = SUM_W'(p_q) + SUM_W'(i_q) + SUM_W'(d_q);
		lim_hi = SUM_W'(cfg.out_max);
		lim_lo = SUM_W'(cfg.out_min);
		if (sum > lim_hi) begin
			drive_n = cfg.out_max;
			hit     = 1'b1;
		end else if (sum < lim_lo) begin
			drive_n = cfg.out_min;
			hit     = 1'b1;
		end else begin
			drive_n = sum[DATA_W-1:0];
			hit     = 1'b0;
		end
	end

	assign div_start = ctrl.en && (ctrl.op == OP_DIV_START);

	pcu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (den_q),
		.busy     (div_busy),
		.quotient (quot)
	);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			tgt_q  <= target;
			meas_q <= measured;
			dt_q   <= step_time;
			clr_q  <= clear_integral;
		end
		if (ctrl.en && mul_en) begin
			prod_q <= prod_n;
		end
		if (ctrl.en) begin
			case (ctrl.op)
				OP_ERR: begin
					err_q  <= err_n;
					diff_q <= MUL_W'(meas_q) - MUL_W'(prev_q);
				end
				OP_MUL_INC:   p_q   <= prod_q[WIDE_W-1:FRAC_BITS];
				OP_MUL_IH:    il_q  <= prod_q[DATA_W+FRAC_BITS-1:FRAC_BITS];
				OP_ISUM:      i_q   <= i_n;
				OP_MUL_DEN:   d_q   <= '0;
				OP_MUL_NUM:   den_q <= prod_q[DEN_W-1:0];
				OP_DIV_START: neg_q <= prod_q[WIDE_W-1];
				OP_DVAL:      d_q   <= quot_s[D_W-1:0];
				OP_SUM: begin
					drive_q   <= drive_n;
					error_q   <= err_q;
					clamped_q <= hit;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			prev_q      <= '0;
			windup_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !(ctrl.en && ctrl.op == OP_SUM)) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.en) begin
				case (ctrl.op)
					OP_ERR: begin
						prev_q <= meas_q;
						if (clr_q) begin
							acc_q <= '0;
						end
					end
					OP_ACC: begin
						// freeze the integral while the last output sat on a limit
						if (!windup_q) begin
							acc_q <= acc_n;
						end
					end
					OP_SUM: begin
						windup_q    <= hit;
						out_valid_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	assign stat.dt_zero  = (dt_q == '0);
	assign stat.div_busy = div_busy;
	assign stat.out_full = out_valid_q && out_stall;

	assign out_valid   = out_valid_q;
	assign drive       = drive_q;
	assign error_value = error_q;
	assign clamped     = clamped_q;

endmodule
